// ----- hw/rtl/key_event_ring_fifo_assert.svh -----
// Assertion macros used by the checker file kerf_checker.sv.
`ifndef KEY_EVENT_RING_FIFO_ASSERT_SVH
`define KEY_EVENT_RING_FIFO_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define KERF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key ring check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define KERF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key ring check failed");

`endif

// ----- hw/rtl/kerf_pkg.sv -----
package kerf_pkg;

  localparam int DEPTH  = 256;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CODE_W = 16;
  localparam int FILL_W = 8;
  localparam int FILL_MAX = (1 << FILL_W) - 1;

  localparam logic [CODE_W-1:0] SCAN_OFFSET = 16'hFF00;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2
  } req_type_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] key_scan;
    logic [CODE_W-1:0] key_unicode;
  } kerf_req_t;

  typedef struct packed {
    logic              key_valid;
    logic              dropped_oldest;
    logic [FILL_W-1:0] fill_count;
    logic              not_empty;
  } kerf_status_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- hw/rtl/key_event_ring_fifo.sv -----
// Pipeline: input register, then result register, between input request and result.
// Throughput: one request per cycle while the result is not stalled; the store has one write and one read port.
// Each request gives exactly one result; a stalled result holds while the next request waits.
// Reset (rst_n low, synchronous) clears both pointers and the pipeline valids; the store
// itself is not cleared and holds nothing readable until written.
module key_event_ring_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [15:0] key_unicode, [31:16] key_scan
  input  logic [1:0]  in_tuser,  // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] key_code, [16] key_valid, [17] dropped_oldest, [25:18] fill_count,
  // [26] not_empty, [31:27] zero
  output logic [31:0] out_tdata
);
  import kerf_pkg::*;

  kerf_req_t         req_r;
  logic              req_valid_r;
  kerf_status_t      status_nxt;
  kerf_status_t      status_r;
  logic              res_valid_r;
  logic              adv;
  logic [CODE_W-1:0] rd_data_r;
  logic [CODE_W-1:0] key_code;

  assign adv       = req_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !req_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        req_valid_r <= in_tvalid;
      end
      if (adv) begin
        res_valid_r <= 1'b1;
      end else if (out_tready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.req_type    <= in_tuser;
      req_r.key_unicode <= in_tdata[15:0];
      req_r.key_scan    <= in_tdata[31:16];
    end
    if (adv) begin
      status_r <= status_nxt;
    end
  end

  kerf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .req        (req_r),
    .status_nxt (status_nxt),
    .rd_data_r  (rd_data_r)
  );

  assign key_code   = status_r.key_valid ? rd_data_r : '0;
  assign out_tvalid = res_valid_r;
  assign out_tdata  = {5'b0, status_r.not_empty, status_r.fill_count,
                       status_r.dropped_oldest, status_r.key_valid, key_code};

endmodule

// ----- hw/rtl/kerf_core.sv -----
module kerf_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  kerf_pkg::kerf_req_t        req,
  output kerf_pkg::kerf_status_t     status_nxt,
  output logic [kerf_pkg::CODE_W-1:0] rd_data_r
);
  import kerf_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];

  ptr_t wp_r, wp_nxt;
  ptr_t rp_r, rp_nxt;
  logic              have_key;
  logic              push_en;
  logic [CODE_W-1:0] push_code;
  logic [PTR_W-1:0]  fill;
  logic              popped;
  logic              dropped;

  assign have_key  = (req.key_unicode != '0) || (req.key_scan != '0);
  assign push_code = (req.key_unicode != '0) ? req.key_unicode : req.key_scan + SCAN_OFFSET;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    push_en = 1'b0;
    popped  = 1'b0;
    dropped = 1'b0;
    case (req.req_type)
      REQ_PUSH: begin
        if (have_key) begin
          push_en = 1'b1;
          wp_nxt  = ring_next(wp_r);
          // full ring: drop the oldest entry
          if (ring_next(wp_r) == rp_r) begin
            rp_nxt  = ring_next(rp_r);
            dropped = 1'b1;
          end
        end
      end
      REQ_POP: begin
        if (wp_r != rp_r) begin
          popped = 1'b1;
          rp_nxt = ring_next(rp_r);
        end
      end
      REQ_FLUSH: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      fill = wp_nxt - rp_nxt;
    end else begin
      fill = PTR_W'({1'b0, wp_nxt} + (PTR_W + 1)'(DEPTH) - {1'b0, rp_nxt});
    end
  end

  always_comb begin
    status_nxt.key_valid      = popped;
    status_nxt.dropped_oldest = dropped;
    status_nxt.fill_count     = (32'(fill) > 32'(FILL_MAX)) ? FILL_W'(FILL_MAX) : FILL_W'(fill);
    status_nxt.not_empty      = (fill != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else if (adv) begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // Read the oldest entry alongside the request; the top level gates it by key_valid.
  always_ff @(posedge clk) begin
    if (adv && push_en) begin
      mem[wp_r] <= push_code;
    end
    if (adv) begin
      rd_data_r <= mem[rp_r];
    end
  end

endmodule

// ----- hw/rtl/kerf_checker.sv -----
`include "key_event_ring_fifo_assert.svh"

module kerf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import kerf_pkg::*;

  localparam int FULL_FILL = (DEPTH - 1 > FILL_MAX) ? FILL_MAX : DEPTH - 1;

  `KERF_ASSERT_NXT(a_hold_stalled, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `KERF_ASSERT_IMP(a_code_zero, out_tvalid && !out_tdata[16], out_tdata[15:0] == 16'h0000)
  `KERF_ASSERT_IMP(a_drop_full, out_tvalid && out_tdata[17], out_tdata[25:18] == 8'(FULL_FILL))
  `KERF_ASSERT_IMP(a_not_empty, out_tvalid, out_tdata[26] == (out_tdata[25:18] != 8'h00))

endmodule

bind key_event_ring_fifo kerf_checker u_kerf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
